// ===== hw/rtl/vat_pkg.sv =====
package vat_pkg;

   // Default geometry of the screen and of the CSI argument list.
   localparam int COLUMNS_DEF  = 40;
   localparam int ROWS_DEF     = 17;
   localparam int MAX_ARGS_DEF = 3;

   // Fixed field widths of the word on either channel.
   localparam int BYTE_W = 8;
   localparam int COL_W  = 6;
   localparam int ROW_W  = 5;

   // Request kinds carried in tuser.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Character codes.
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_ULINE    = "_";
   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_CR       = 8'h0d;
   localparam logic [7:0] CH_LF       = 8'h0a;
   localparam logic [7:0] CH_CSI8     = 8'h9b;
   localparam logic [7:0] CH_LBRACK   = "[";
   localparam logic [7:0] CH_TILDE    = 8'h7e;
   localparam logic [7:0] CH_FINAL_LO = 8'h40;
   localparam logic [7:0] CH_UTF_LO   = 8'd194;
   localparam logic [7:0] CH_UTF_HI   = 8'd197;
   localparam logic [7:0] CH_UTF_E2   = 8'd226;
   localparam logic [7:0] CH_Y_BIAS   = 8'd32;
   localparam logic [7:0] CH_0        = "0";
   localparam logic [7:0] CH_9        = "9";
   localparam logic [7:0] CH_COMMA    = ",";
   localparam logic [7:0] CH_SEMI     = ";";
   localparam logic [7:0] CH_COLON    = ":";
   localparam logic [7:0] CH_A        = "A";
   localparam logic [7:0] CH_B        = "B";
   localparam logic [7:0] CH_C        = "C";
   localparam logic [7:0] CH_D        = "D";
   localparam logic [7:0] CH_E        = "E";
   localparam logic [7:0] CH_F        = "F";
   localparam logic [7:0] CH_G        = "G";
   localparam logic [7:0] CH_H        = "H";
   localparam logic [7:0] CH_I        = "I";
   localparam logic [7:0] CH_J        = "J";
   localparam logic [7:0] CH_K        = "K";
   localparam logic [7:0] CH_S        = "S";
   localparam logic [7:0] CH_T        = "T";
   localparam logic [7:0] CH_Y        = "Y";
   localparam logic [7:0] CH_LOW_F    = "f";
   localparam logic [7:0] ARG_DELETE  = 8'd3;

   typedef enum logic [3:0] {
      ST_CLEAR_LOAD,
      ST_IDLE,
      ST_EXEC,
      ST_STEP,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ESC,
      PH_CSI,
      PH_YROW,
      PH_YCOL
   } phase_type;

   typedef enum logic [3:0] {
      CUR_NONE,
      CUR_UP,
      CUR_LF_KEEP,
      CUR_LF,
      CUR_RIGHT,
      CUR_LEFT,
      CUR_COL0,
      CUR_SET,
      CUR_SETCOL
   } cur_op_type;

   typedef enum logic [3:0] {
      RG_SCRUP_MOVE,
      RG_SCRUP_FILL,
      RG_SCRDN_MOVE,
      RG_SCRDN_FILL,
      RG_CUR_END,
      RG_START_CUR,
      RG_ALL,
      RG_CUR_EOL,
      RG_SOL_CUR,
      RG_LINE,
      RG_DEL_MOVE,
      RG_DEL_FILL,
      RG_PRINT
   } region_type;

   typedef enum logic [2:0] {
      K_UP,
      K_DOWN,
      K_RIGHT,
      K_LEFT,
      K_NL,
      K_SCRUP,
      K_SCRDN,
      K_REV
   } step_kind_type;

   typedef enum logic [1:0] {
      AFT_STEP,
      AFT_DONE,
      AFT_IDLE
   } after_type;

   typedef struct packed {
      cur_op_type       cur_op;
      logic [7:0]       set_row;
      logic [7:0]       set_col;
      logic             mem_load;
      region_type       region;
      logic [7:0]       fill_char;
      logic             move_step;
      logic             fill_step;
      logic             rd_issue;
      logic             cell_read;
      logic [COL_W-1:0] rd_col;
      logic [ROW_W-1:0] rd_row;
      logic             rsp_load;
      logic             rsp_read;
      logic             touched;
   } dp_cmd_type;

   typedef struct packed {
      logic at_top;
      logic at_bottom;
      logic at_right;
      logic cnt_zero;
   } dp_stat_type;

endpackage

// ===== hw/rtl/vat_dpath.sv =====
module vat_dpath
   import vat_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   output logic [BYTE_W-1:0] rsp_read_char,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic              rsp_screen_changed
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS + 1);
   localparam int IW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int LW    = $clog2(ROWS);

   logic [CW-1:0] col_ff, col_in;
   logic [LW-1:0] line_ff, line_in;
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff, cnt_ff;
   logic          down_ff;
   logic [7:0]    val_ff;
   logic [7:0]    rdata_ff;
   logic          in_range_ff;
   logic [7:0]    mem [CELLS];

   logic [AW-1:0] here, rowstart, cell_addr;
   logic [AW-1:0] ld_dst, ld_src, ld_cnt;
   logic          ld_down;
   logic [7:0]    ld_val;
   logic          in_range, we, re;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    wdata;

   assign rowstart = AW'(line_ff) * AW'(COLUMNS);
   assign here     = rowstart + AW'(col_ff);

   assign stat.at_top    = (line_ff == '0);
   assign stat.at_bottom = (line_ff == LW'(ROWS - 1));
   assign stat.at_right  = (col_ff == CW'(COLUMNS - 1));
   assign stat.cnt_zero  = (cnt_ff == '0);

   // Start, source, length, direction and fill value of each block operation on the screen.
   always_comb begin
      ld_dst  = '0;
      ld_src  = '0;
      ld_cnt  = '0;
      ld_down = 1'b0;
      ld_val  = CH_SPACE;
      unique case (cmd.region)
         RG_SCRUP_MOVE: begin
            ld_src = AW'(COLUMNS);
            ld_cnt = AW'(CELLS - COLUMNS);
         end
         RG_SCRUP_FILL: begin
            ld_dst = AW'(CELLS - COLUMNS);
            ld_cnt = AW'(COLUMNS);
         end
         RG_SCRDN_MOVE: begin
            ld_src  = AW'(CELLS - COLUMNS - 1);
            ld_dst  = AW'(CELLS - 1);
            ld_cnt  = AW'(CELLS - COLUMNS);
            ld_down = 1'b1;
         end
         RG_SCRDN_FILL: ld_cnt = AW'(COLUMNS);
         RG_CUR_END: begin
            ld_dst = here;
            ld_cnt = AW'(CELLS) - here;
         end
         RG_START_CUR: ld_cnt = here;
         RG_ALL:       ld_cnt = AW'(CELLS);
         RG_CUR_EOL: begin
            ld_dst = here;
            ld_cnt = AW'(COLUMNS) - AW'(col_ff);
         end
         RG_SOL_CUR: begin
            ld_dst = rowstart;
            ld_cnt = AW'(col_ff);
         end
         RG_LINE: begin
            ld_dst = rowstart;
            ld_cnt = AW'(COLUMNS);
         end
         RG_DEL_MOVE: begin
            ld_src = here + AW'(1);
            ld_dst = here;
            ld_cnt = AW'(COLUMNS - 1) - AW'(col_ff);
         end
         RG_DEL_FILL: begin
            ld_dst = rowstart + AW'(COLUMNS - 1);
            ld_cnt = AW'(1);
         end
         RG_PRINT: begin
            ld_dst = here;
            ld_cnt = AW'(1);
            ld_val = cmd.fill_char;
         end
         default: ld_cnt = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_load) begin
         wr_ptr_ff <= ld_dst;
         rd_ptr_ff <= ld_src;
         cnt_ff    <= ld_cnt;
         down_ff   <= ld_down;
         val_ff    <= ld_val;
      end else if (cmd.move_step) begin
         wr_ptr_ff <= down_ff ? wr_ptr_ff - AW'(1) : wr_ptr_ff + AW'(1);
         rd_ptr_ff <= down_ff ? rd_ptr_ff - AW'(1) : rd_ptr_ff + AW'(1);
         cnt_ff    <= cnt_ff - AW'(1);
      end else if (cmd.fill_step) begin
         wr_ptr_ff <= wr_ptr_ff + AW'(1);
         cnt_ff    <= cnt_ff - AW'(1);
      end
   end

   assign in_range  = (int'(cmd.rd_row) < ROWS) && (int'(cmd.rd_col) < COLUMNS);
   assign cell_addr = AW'(cmd.rd_row) * AW'(COLUMNS) + AW'(cmd.rd_col);

   assign we    = cmd.move_step | cmd.fill_step;
   assign waddr = wr_ptr_ff;
   assign wdata = cmd.move_step ? rdata_ff : val_ff;
   assign re    = cmd.rd_issue | (cmd.cell_read & in_range);
   assign raddr = cmd.cell_read ? cell_addr : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr[IW-1:0]] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr[IW-1:0]];
      end
      if (cmd.cell_read) begin
         in_range_ff <= in_range;
      end
   end

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      unique case (cmd.cur_op)
         CUR_NONE: col_in = col_ff;
         CUR_UP: begin
            if (line_ff != '0) line_in = line_ff - LW'(1);
         end
         CUR_LF_KEEP: begin
            if (!stat.at_bottom) line_in = line_ff + LW'(1);
         end
         CUR_LF: begin
            col_in = '0;
            if (!stat.at_bottom) line_in = line_ff + LW'(1);
         end
         CUR_RIGHT: col_in = col_ff + CW'(1);
         CUR_LEFT: begin
            if (col_ff != '0) begin
               col_in = col_ff - CW'(1);
            end else if (line_ff != '0) begin
               col_in  = CW'(COLUMNS - 1);
               line_in = line_ff - LW'(1);
            end
         end
         CUR_COL0: col_in = '0;
         CUR_SET: begin
            line_in = LW'(cmd.set_row);
            col_in  = CW'(cmd.set_col);
         end
         CUR_SETCOL: col_in = CW'(cmd.set_col);
         default: col_in = col_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
      end else begin
         col_ff  <= col_in;
         line_ff <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_read_char      <= (cmd.rsp_read && in_range_ff) ? rdata_ff : '0;
         rsp_cursor_col     <= COL_W'(col_ff);
         rsp_cursor_row     <= ROW_W'(line_ff);
         rsp_screen_changed <= cmd.touched;
      end
   end

endmodule

// ===== hw/rtl/vat_ctrl.sv =====
module vat_ctrl
   import vat_pkg::*;
#(
   parameter int COLUMNS  = COLUMNS_DEF,
   parameter int ROWS     = ROWS_DEF,
   parameter int MAX_ARGS = MAX_ARGS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_command,
   input  logic [7:0]       req_data_byte,
   input  logic [COL_W-1:0] req_read_col,
   input  logic [ROW_W-1:0] req_read_row,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output dp_cmd_type       cmd,
   input  dp_stat_type      stat
);

   localparam int AIW  = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
   localparam int BIDX = (MAX_ARGS > 1) ? 1 : 0;

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [7:0]    pending_ff, pending_in;
   logic [7:0]    args_ff [MAX_ARGS];
   logic [AIW-1:0] idx_ff, idx_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    rep_ff, rep_in;
   step_kind_type kind_ff, kind_in;
   after_type     after_ff, after_in;
   region_type    fillrg_ff, fillrg_in;
   logic          is_read_ff, byte_we;
   logic [7:0]    byte_ff;
   logic [COL_W-1:0] rcol_ff;
   logic [ROW_W-1:0] rrow_ff;
   logic          touched_ff, touched_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Decoded plan for the captured word.
   cur_op_type    pl_cur_op;
   logic [7:0]    pl_set_row, pl_set_col, pl_fill_char, pl_rep, pl_digit_val;
   logic          pl_load, pl_args_clr, pl_digit_we, pl_idx_inc, pl_ovf_set, pl_pending_we;
   region_type    pl_region, pl_fillrg;
   state_type     pl_next;
   step_kind_type pl_kind;
   after_type     pl_after;
   phase_type     pl_phase;

   // Plan for one repetition of a cursor step.
   cur_op_type    sp_cur_op;
   logic          sp_load;
   region_type    sp_region, sp_fillrg;

   logic [7:0]  c, arg_a, arg_b, n_val, n_m1, b_m1, arg_cur;
   logic [11:0] digit_sum;
   logic        rsp_free;

   function automatic logic [7:0] sat_row(input logic [7:0] v);
      return (v > 8'(ROWS - 1)) ? 8'(ROWS - 1) : v;
   endfunction

   function automatic logic [7:0] sat_col(input logic [7:0] v);
      return (v > 8'(COLUMNS - 1)) ? 8'(COLUMNS - 1) : v;
   endfunction

   function automatic logic [7:0] y_off(input logic [7:0] v);
      return (v < CH_Y_BIAS) ? 8'd0 : v - CH_Y_BIAS;
   endfunction

   assign c         = byte_ff;
   assign arg_a     = args_ff[0];
   assign arg_b     = (MAX_ARGS > 1) ? args_ff[BIDX] : 8'd0;
   assign n_val     = (arg_a == 8'd0) ? 8'd1 : arg_a;
   assign n_m1      = (arg_a == 8'd0) ? 8'd0 : arg_a - 8'd1;
   assign b_m1      = (arg_b == 8'd0) ? 8'd0 : arg_b - 8'd1;
   assign arg_cur   = args_ff[idx_ff];
   assign digit_sum = 12'(arg_cur) * 12'd10 + 12'(c - CH_0);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      pl_cur_op     = CUR_NONE;
      pl_set_row    = '0;
      pl_set_col    = '0;
      pl_fill_char  = CH_SPACE;
      pl_rep        = 8'd1;
      pl_load       = 1'b0;
      pl_region     = RG_ALL;
      pl_fillrg     = RG_ALL;
      pl_next       = ST_DONE;
      pl_kind       = K_UP;
      pl_after      = AFT_DONE;
      pl_phase      = phase_ff;
      pl_args_clr   = 1'b0;
      pl_digit_we   = 1'b0;
      pl_digit_val  = (digit_sum > 12'd255) ? 8'd255 : digit_sum[7:0];
      pl_idx_inc    = 1'b0;
      pl_ovf_set    = 1'b0;
      pl_pending_we = 1'b0;
      if (is_read_ff == CMD_BYTE) begin
         unique case (phase_ff)
            PH_ESC: begin
               pl_phase = PH_IDLE;
               unique case (c)
                  CH_A: pl_next = ST_STEP;
                  CH_B: begin pl_kind = K_DOWN;  pl_next = ST_STEP; end
                  CH_C: begin pl_kind = K_RIGHT; pl_next = ST_STEP; end
                  CH_D: begin pl_kind = K_LEFT;  pl_next = ST_STEP; end
                  CH_E: begin pl_kind = K_NL;    pl_next = ST_STEP; end
                  CH_H: pl_cur_op = CUR_SET;
                  CH_I: begin pl_kind = K_REV;   pl_next = ST_STEP; end
                  CH_J: begin
                     pl_load = 1'b1; pl_region = RG_CUR_END; pl_next = ST_FILL;
                  end
                  CH_K: begin
                     pl_load = 1'b1; pl_region = RG_CUR_EOL; pl_next = ST_FILL;
                  end
                  CH_Y: pl_phase = PH_YROW;
                  CH_LBRACK, CH_CSI8: begin
                     pl_args_clr = 1'b1;
                     pl_phase    = PH_CSI;
                  end
                  default: pl_next = ST_DONE;
               endcase
            end
            PH_YROW: begin
               pl_pending_we = 1'b1;
               pl_phase      = PH_YCOL;
            end
            PH_YCOL: begin
               pl_cur_op  = CUR_SET;
               pl_set_row = sat_row(y_off(pending_ff));
               pl_set_col = sat_col(y_off(c));
               pl_phase   = PH_IDLE;
            end
            PH_CSI: begin
               priority if (c < CH_SPACE || c > CH_TILDE) begin
                  pl_phase = PH_IDLE;
               end else if (c >= CH_0 && c <= CH_9) begin
                  pl_digit_we = 1'b1;
               end else if (c == CH_COMMA || c == CH_SEMI || c == CH_COLON) begin
                  if (int'(idx_ff) + 1 < MAX_ARGS) pl_idx_inc = 1'b1;
                  else pl_ovf_set = 1'b1;
               end else if (c > CH_FINAL_LO) begin
                  pl_phase = PH_IDLE;
                  if (!ovf_ff) begin
                     pl_rep = n_val;
                     unique case (c)
                        CH_A: pl_next = ST_STEP;
                        CH_B: begin pl_kind = K_DOWN;  pl_next = ST_STEP; end
                        CH_C: begin pl_kind = K_RIGHT; pl_next = ST_STEP; end
                        CH_D: begin pl_kind = K_LEFT;  pl_next = ST_STEP; end
                        CH_E: begin pl_kind = K_NL;    pl_next = ST_STEP; end
                        CH_F: begin pl_cur_op = CUR_COL0; pl_next = ST_STEP; end
                        CH_G: begin
                           pl_cur_op  = CUR_SETCOL;
                           pl_set_col = sat_col(n_m1);
                        end
                        CH_H, CH_LOW_F: begin
                           pl_cur_op  = CUR_SET;
                           pl_set_row = sat_row(n_m1);
                           pl_set_col = sat_col(b_m1);
                        end
                        CH_J: begin
                           pl_load = 1'b1;
                           pl_next = ST_FILL;
                           if (arg_a == 8'd0) begin
                              pl_region = RG_CUR_END;
                           end else if (arg_a == 8'd1) begin
                              pl_region = RG_START_CUR;
                           end else begin
                              pl_region = RG_ALL;
                              pl_cur_op = CUR_SET;
                           end
                        end
                        CH_K: begin
                           pl_load = 1'b1;
                           pl_next = ST_FILL;
                           if (arg_a == 8'd0) pl_region = RG_CUR_EOL;
                           else if (arg_a == 8'd1) pl_region = RG_SOL_CUR;
                           else pl_region = RG_LINE;
                        end
                        CH_S: begin pl_kind = K_SCRUP; pl_next = ST_STEP; end
                        CH_T: begin pl_kind = K_SCRDN; pl_next = ST_STEP; end
                        CH_TILDE: begin
                           if (arg_a == ARG_DELETE) begin
                              pl_load   = 1'b1;
                              pl_region = RG_DEL_MOVE;
                              pl_fillrg = RG_DEL_FILL;
                              pl_next   = ST_MOVE_RD;
                           end
                        end
                        default: pl_next = ST_DONE;
                     endcase
                  end
               end else begin
                  pl_next = ST_DONE;
               end
            end
            default: begin
               pl_phase = PH_IDLE;
               priority if ((c >= CH_UTF_LO && c <= CH_UTF_HI) || c == CH_UTF_E2) begin
                  pl_next = ST_DONE;
               end else if (c == CH_ESC) begin
                  pl_phase = PH_ESC;
               end else if (c == CH_CR) begin
                  pl_cur_op = CUR_COL0;
               end else if (c == CH_LF) begin
                  pl_kind = K_NL;
                  pl_next = ST_STEP;
               end else begin
                  // Any other byte: write the cell (an underscore for a control byte), then advance as a right move.
                  pl_load      = 1'b1;
                  pl_region    = RG_PRINT;
                  pl_fill_char = (c < CH_SPACE) ? CH_ULINE : c;
                  pl_kind      = K_RIGHT;
                  pl_after     = AFT_STEP;
                  pl_next      = ST_FILL;
               end
            end
         endcase
      end
   end

   always_comb begin
      sp_cur_op = CUR_NONE;
      sp_load   = 1'b0;
      sp_region = RG_SCRUP_MOVE;
      sp_fillrg = RG_SCRUP_FILL;
      unique case (kind_ff)
         K_UP:   sp_cur_op = CUR_UP;
         K_DOWN: begin
            sp_cur_op = CUR_LF_KEEP;
            sp_load   = stat.at_bottom;
         end
         K_NL: begin
            sp_cur_op = CUR_LF;
            sp_load   = stat.at_bottom;
         end
         K_RIGHT: begin
            if (stat.at_right) begin
               sp_cur_op = CUR_LF;
               sp_load   = stat.at_bottom;
            end else begin
               sp_cur_op = CUR_RIGHT;
            end
         end
         K_LEFT:  sp_cur_op = CUR_LEFT;
         K_SCRUP: sp_load = 1'b1;
         K_SCRDN: begin
            sp_load   = 1'b1;
            sp_region = RG_SCRDN_MOVE;
            sp_fillrg = RG_SCRDN_FILL;
         end
         K_REV: begin
            if (stat.at_top) begin
               sp_load   = 1'b1;
               sp_region = RG_SCRDN_MOVE;
               sp_fillrg = RG_SCRDN_FILL;
            end else begin
               sp_cur_op = CUR_UP;
            end
         end
         default: sp_cur_op = CUR_NONE;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR_LOAD: state_in = ST_FILL;
         ST_IDLE:       if (req_tvalid) state_in = ST_EXEC;
         ST_EXEC:       state_in = pl_next;
         ST_STEP: begin
            if (rep_ff == 8'd0) state_in = ST_DONE;
            else if (sp_load) state_in = ST_MOVE_RD;
         end
         ST_MOVE_RD:    state_in = stat.cnt_zero ? ST_FILL : ST_MOVE_WR;
         ST_MOVE_WR:    state_in = ST_MOVE_RD;
         ST_FILL: begin
            if (stat.cnt_zero) begin
               unique case (after_ff)
                  AFT_STEP: state_in = ST_STEP;
                  AFT_IDLE: state_in = ST_IDLE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_DONE:       if (rsp_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs and register updates.
   always_comb begin
      cmd           = '0;
      cmd.cur_op    = CUR_NONE;
      cmd.region    = RG_ALL;
      cmd.fill_char = pl_fill_char;
      cmd.set_row   = pl_set_row;
      cmd.set_col   = pl_set_col;
      cmd.rd_col    = rcol_ff;
      cmd.rd_row    = rrow_ff;
      cmd.rsp_read  = is_read_ff;
      cmd.touched   = touched_ff;
      phase_in      = phase_ff;
      pending_in    = pending_ff;
      idx_in        = idx_ff;
      ovf_in        = ovf_ff;
      rep_in        = rep_ff;
      kind_in       = kind_ff;
      after_in      = after_ff;
      fillrg_in     = fillrg_ff;
      touched_in    = touched_ff;
      byte_we       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CLEAR_LOAD: begin
            cmd.mem_load = 1'b1;
            cmd.region   = RG_ALL;
            after_in     = AFT_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_we    = 1'b1;
               touched_in = 1'b0;
            end
         end
         ST_EXEC: begin
            cmd.cur_op    = pl_cur_op;
            cmd.mem_load  = pl_load;
            cmd.region    = pl_region;
            cmd.cell_read = (is_read_ff == CMD_READ);
            phase_in      = pl_phase;
            if (pl_pending_we) pending_in = c;
            if (pl_args_clr) begin
               idx_in = '0;
               ovf_in = 1'b0;
            end
            if (pl_idx_inc) idx_in = idx_ff + AIW'(1);
            if (pl_ovf_set) ovf_in = 1'b1;
            rep_in     = pl_rep;
            kind_in    = pl_kind;
            after_in   = pl_after;
            fillrg_in  = pl_fillrg;
            touched_in = touched_ff | pl_load;
         end
         ST_STEP: begin
            if (rep_ff != 8'd0) begin
               rep_in     = rep_ff - 8'd1;
               cmd.cur_op = sp_cur_op;
               if (sp_load) begin
                  cmd.mem_load = 1'b1;
                  cmd.region   = sp_region;
                  fillrg_in    = sp_fillrg;
                  after_in     = AFT_STEP;
                  touched_in   = 1'b1;
               end
            end
         end
         ST_MOVE_RD: begin
            if (stat.cnt_zero) begin
               cmd.mem_load = 1'b1;
               cmd.region   = fillrg_ff;
            end else begin
               cmd.rd_issue = 1'b1;
            end
         end
         ST_MOVE_WR: cmd.move_step = 1'b1;
         ST_FILL:    cmd.fill_step = !stat.cnt_zero;
         ST_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd.cur_op = CUR_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR_LOAD;
         phase_ff     <= PH_IDLE;
         pending_ff   <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         touched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ARGS; i++) args_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         touched_ff   <= touched_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_EXEC && pl_args_clr) begin
            for (int i = 0; i < MAX_ARGS; i++) args_ff[i] <= '0;
         end else if (state_ff == ST_EXEC && pl_digit_we) begin
            args_ff[idx_ff] <= pl_digit_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      rep_ff    <= rep_in;
      kind_ff   <= kind_in;
      after_ff  <= after_in;
      fillrg_ff <= fillrg_in;
      if (byte_we) begin
         is_read_ff <= req_command;
         byte_ff    <= req_data_byte;
         rcol_ff    <= req_read_col;
         rrow_ff    <= req_read_row;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hw/rtl/vt52_ansi_text_terminal.sv =====
// Channel  Direction  Ports                    Word
// req      in         req_tvalid/tready/tdata   one terminal byte or one cell read
//                     req_tuser                 request kind
// rsp      out        rsp_tvalid/tready/tdata   read cell, cursor, change flag
//
// A printed byte writes its cell and then takes a cursor step; a repeated CSI move
// takes its steps one after another. A scroll walks the screen store through its single
// write port, reading and then writing each cell, and then fills the freed line with
// spaces; erases write the cells one at a time. After reset a clearing pass fills the
// screen with spaces, with req_tready low. A new word is taken while a result waits on a
// stalled rsp side; the block then holds its next result until the waiting one is taken.
module vt52_ansi_text_terminal
   import vat_pkg::*;
#(
   parameter int COLUMNS  = COLUMNS_DEF,
   parameter int ROWS     = ROWS_DEF,
   parameter int MAX_ARGS = MAX_ARGS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // data_byte[7:0], read_col[13:8], read_row[18:14], zero
   input  logic [0:0]  req_tuser,  // command[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // read_char[7:0], cursor_col[13:8], cursor_row[18:14],
                                   // screen_changed[19], zero
);

   dp_cmd_type       cmd;
   dp_stat_type      stat;
   logic [7:0]       read_char;
   logic [COL_W-1:0] cursor_col;
   logic [ROW_W-1:0] cursor_row;
   logic             screen_changed;

   vat_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .MAX_ARGS(MAX_ARGS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_command  (req_tuser[0]),
      .req_data_byte(req_tdata[7:0]),
      .req_read_col (req_tdata[13:8]),
      .req_read_row (req_tdata[18:14]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .cmd          (cmd),
      .stat         (stat)
   );

   vat_dpath #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_read_char     (read_char),
      .rsp_cursor_col    (cursor_col),
      .rsp_cursor_row    (cursor_row),
      .rsp_screen_changed(screen_changed)
   );

   assign rsp_tdata = {4'b0000, screen_changed, cursor_row, cursor_col, read_char};

endmodule
